[design/gzhc_pkg.sv]
// Shared types and constants for the gzip member header and trailer checker.
package gzhc_pkg;

    localparam logic [7:0] MAGIC_ID1    = 8'h1F;
    localparam logic [7:0] MAGIC_ID2    = 8'h8B;
    localparam logic [7:0] CM_DEFLATE   = 8'h08;
    localparam logic [7:0] FLG_RESERVED = 8'hE0;

    // Bit positions inside the FLG byte.
    localparam int FLG_BIT_HCRC    = 1;
    localparam int FLG_BIT_EXTRA   = 2;
    localparam int FLG_BIT_NAME    = 3;
    localparam int FLG_BIT_COMMENT = 4;

    localparam int FIXED_LAST   = 9;
    localparam int TRAILER_LAST = 7;

    typedef enum logic [2:0] {
        ST_HEADER  = 3'd0,
        ST_BODY    = 3'd1,
        ST_TRAILER = 3'd2,
        ST_DONE    = 3'd3,
        ST_ERROR   = 3'd4
    } status_t;

    typedef struct packed {
        logic [31:0] output_length;
        logic [31:0] output_crc;
        logic        body_done;
        logic        source_end;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] payload_byte;
        logic       payload_valid;
    } result_t;

endpackage

[design/gzhc_core.sv]
// Header parser, payload forwarder and trailer compare: state registers and per-byte logic.
module gzhc_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  gzhc_pkg::item_t  item,
    output gzhc_pkg::result_t result
);
    import gzhc_pkg::*;

    typedef enum logic [3:0] {
        PH_FIXED   = 4'd0,
        PH_XLEN    = 4'd1,
        PH_XDATA   = 4'd2,
        PH_NAME    = 4'd3,
        PH_COMMENT = 4'd4,
        PH_HCRC    = 4'd5,
        PH_BODY    = 4'd6,
        PH_TRAILER = 4'd7,
        PH_DONE    = 4'd8,
        PH_ERROR   = 4'd9
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  index_reg, index_next;
    logic [7:0]  flags_reg, flags_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] len_reg, len_next;
    logic        mismatch_reg, mismatch_next;

    logic [15:0] xlen_full;
    logic [15:0] xlen_dec;
    logic [2:0]  trailer_k;
    logic [31:0] trailer_word;
    logic [7:0]  trailer_want;

    // First optional header part at or after 'from' that the flags call for.
    function automatic phase_t advance(phase_t from, logic [7:0] flg, logic xlen_nonzero);
        phase_t p;
        if (from <= PH_XLEN && flg[FLG_BIT_EXTRA]) begin
            p = PH_XLEN;
        end else if (from == PH_XDATA && xlen_nonzero) begin
            p = PH_XDATA;
        end else if (from <= PH_NAME && flg[FLG_BIT_NAME]) begin
            p = PH_NAME;
        end else if (from <= PH_COMMENT && flg[FLG_BIT_COMMENT]) begin
            p = PH_COMMENT;
        end else if (from <= PH_HCRC && flg[FLG_BIT_HCRC]) begin
            p = PH_HCRC;
        end else begin
            p = PH_BODY;
        end
        return p;
    endfunction

    assign xlen_full    = {item.data_byte, len_reg[7:0]};
    assign xlen_dec     = len_reg[15:0] - 16'd1;
    assign trailer_k    = index_reg[2:0];
    assign trailer_word = trailer_k[2] ? len_reg : crc_reg;
    assign trailer_want = trailer_word[{trailer_k[1:0], 3'b000} +: 8];

    always_comb begin
        phase_next    = phase_reg;
        index_next    = index_reg;
        flags_next    = flags_reg;
        crc_next      = crc_reg;
        len_next      = len_reg;
        mismatch_next = mismatch_reg;
        result.payload_valid = 1'b0;
        result.payload_byte  = 8'd0;

        if (phase_reg == PH_DONE || phase_reg == PH_ERROR) begin
            // Terminal phases hold until reset.
        end else if (item.source_end) begin
            phase_next = PH_ERROR;
        end else if (item.body_done) begin
            if (phase_reg == PH_BODY) begin
                crc_next      = item.output_crc;
                len_next      = item.output_length;
                mismatch_next = 1'b0;
                index_next    = 4'd0;
                phase_next    = PH_TRAILER;
            end
        end else begin
            unique case (phase_reg)
                PH_FIXED: begin
                    if ((index_reg == 4'd0 && item.data_byte != MAGIC_ID1) ||
                        (index_reg == 4'd1 && item.data_byte != MAGIC_ID2) ||
                        (index_reg == 4'd2 && item.data_byte != CM_DEFLATE) ||
                        (index_reg == 4'd3 && (item.data_byte & FLG_RESERVED) != 8'd0)) begin
                        phase_next = PH_ERROR;
                    end else begin
                        if (index_reg == 4'd3) begin
                            flags_next = item.data_byte;
                        end
                        if (index_reg == 4'(FIXED_LAST)) begin
                            len_next   = 32'd0;
                            index_next = 4'd0;
                            phase_next = advance(PH_XLEN, flags_reg, 1'b0);
                        end else begin
                            index_next = index_reg + 4'd1;
                        end
                    end
                end
                PH_XLEN: begin
                    if (index_reg == 4'd0) begin
                        len_next   = {24'd0, item.data_byte};
                        index_next = 4'd1;
                    end else begin
                        len_next   = {16'd0, xlen_full};
                        index_next = 4'd0;
                        phase_next = advance(PH_XDATA, flags_reg, xlen_full != 16'd0);
                    end
                end
                PH_XDATA: begin
                    len_next = {16'd0, xlen_dec};
                    if (xlen_dec == 16'd0) begin
                        index_next = 4'd0;
                        phase_next = advance(PH_NAME, flags_reg, 1'b0);
                    end
                end
                PH_NAME: begin
                    if (item.data_byte == 8'd0) begin
                        index_next = 4'd0;
                        phase_next = advance(PH_COMMENT, flags_reg, 1'b0);
                    end
                end
                PH_COMMENT: begin
                    if (item.data_byte == 8'd0) begin
                        index_next = 4'd0;
                        phase_next = advance(PH_HCRC, flags_reg, 1'b0);
                    end
                end
                PH_HCRC: begin
                    if (index_reg == 4'd0) begin
                        index_next = 4'd1;
                    end else begin
                        index_next = 4'd0;
                        phase_next = PH_BODY;
                    end
                end
                PH_BODY: begin
                    result.payload_valid = 1'b1;
                    result.payload_byte  = item.data_byte;
                end
                PH_TRAILER: begin
                    mismatch_next = mismatch_reg | (trailer_want != item.data_byte);
                    if (trailer_k == 3'(TRAILER_LAST)) begin
                        phase_next = mismatch_next ? PH_ERROR : PH_DONE;
                        index_next = 4'd0;
                    end else begin
                        index_next = {1'b0, trailer_k} + 4'd1;
                    end
                end
                default: begin
                    phase_next = PH_ERROR;
                end
            endcase
        end

        unique case (phase_next)
            PH_BODY:    result.status = ST_BODY;
            PH_TRAILER: result.status = ST_TRAILER;
            PH_DONE:    result.status = ST_DONE;
            PH_ERROR:   result.status = ST_ERROR;
            default:    result.status = ST_HEADER;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_FIXED;
            index_reg    <= 4'd0;
            flags_reg    <= 8'd0;
            crc_reg      <= 32'd0;
            len_reg      <= 32'd0;
            mismatch_reg <= 1'b0;
        end else if (accept) begin
            phase_reg    <= phase_next;
            index_reg    <= index_next;
            flags_reg    <= flags_next;
            crc_reg      <= crc_next;
            len_reg      <= len_next;
            mismatch_reg <= mismatch_next;
        end
    end

endmodule

[design/gzip_member_header_trailer_check_top.sv]
// Top level of the gzip member header and trailer checker with its stream ports.
//
// One input transfer carries either a source byte, an end-of-source mark or a
// body-finished mark with the CRC-32 and length of the decompressed data.
// Every input transfer produces exactly one output transfer: the payload byte
// (when the byte belongs to the deflate body) and the status after that item
// (header, body, trailer, done, or data error).
// Output tvalid rises in the cycle after the input transfer, and one item is
// taken every cycle while the output register can take it; the phase register
// is read and rewritten by the byte decode in a single cycle.
// The output stage is one register; s_tready stays high while that register
// is empty or is being emptied in the same cycle, so a stalled receiver holds
// back the source only once the register is full.
// Synchronous active-low reset returns the parser to the start of the fixed
// header and empties the output register. A data error is sticky until reset,
// and after a good trailer every further item reports done.
module gzip_member_header_trailer_check_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // data_byte[7:0], output_crc[39:8], output_length[71:40]
    input  logic [1:0]  s_tuser,   // source_end[0], body_done[1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // payload_byte[7:0]
    output logic [3:0]  m_tuser    // payload_valid[0], status[3:1]
);
    import gzhc_pkg::*;

    logic    accept;
    item_t   item;
    result_t result;

    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg;
    logic [3:0] m_tuser_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign item.data_byte     = s_tdata[7:0];
    assign item.output_crc    = s_tdata[39:8];
    assign item.output_length = s_tdata[71:40];
    assign item.source_end    = s_tuser[0];
    assign item.body_done     = s_tuser[1];

    gzhc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .item    (item),
        .result  (result)
    );

    assign m_tvalid_next = accept || (m_tvalid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        if (accept) begin
            m_tdata_reg <= result.payload_byte;
            m_tuser_reg <= {result.status, result.payload_valid};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid)
        else $error("accepted item did not produce an output transfer");

    a_payload_only_in_body: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tuser[3:1] == ST_BODY))
        else $error("payload byte flagged outside the body phase");

    a_idle_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 8'd0))
        else $error("nonzero payload byte without payload_valid");
`endif

endmodule
